@@ design/mtep_pkg.sv @@
// Shared types, constants and codes of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

    // Width of the variable-length value datapath (default of the top-level parameter).
    localparam int VLQ_BITS_DEF = 28;

    // The chunk header is always the id plus the 32-bit size.
    localparam int HEADER_BYTES = 8;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

    // Field widths of a result record.
    localparam int KIND_W   = 4;
    localparam int DELTA_W  = 28;
    localparam int CHAN_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int SECOND_W = 15;
    localparam int LEN_W    = 28;

    // Status and meta codes.
    localparam logic [7:0] ST_SYSEX  = 8'hF0;
    localparam logic [7:0] ST_ESCAPE = 8'hF7;
    localparam logic [7:0] ST_META   = 8'hFF;
    localparam logic [7:0] META_EOT  = 8'h2F;

    // High nibbles of interest.
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_SYSTEM     = 4'hF;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DELTA   = 3'd1,
        PH_STATUS  = 3'd2,
        PH_FIRST   = 3'd3,
        PH_SECOND  = 3'd4,
        PH_LENGTH  = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_OFF    = 4'd0,
        KIND_NOTE_ON     = 4'd1,
        KIND_POLY_PRESS  = 4'd2,
        KIND_CONTROL     = 4'd3,
        KIND_PROGRAM     = 4'd4,
        KIND_CHAN_PRESS  = 4'd5,
        KIND_PITCH_WHEEL = 4'd6,
        KIND_META_HDR    = 4'd7,
        KIND_SYSEX_HDR   = 4'd8,
        KIND_PAYLOAD     = 4'd9
    } t_kind;

    // Compact event as queued between the parser and the output stage.
    typedef struct packed {
        t_kind               kind;
        logic [DELTA_W-1:0]  delta;
        logic [LEN_W-1:0]    length;
        logic [CHAN_W-1:0]   chan;
        logic [BYTE_W-1:0]   byte_a;   // first data byte, meta type or payload byte
        logic [BYTE_W-1:0]   byte_b;   // second data byte
        logic                flag;     // last payload or end of track
    } t_evt;

    // Fully expanded result record.
    typedef struct packed {
        t_kind               event_kind;
        logic [DELTA_W-1:0]  delta_time;
        logic [CHAN_W-1:0]   channel_number;
        logic [BYTE_W-1:0]   first_value;
        logic [SECOND_W-1:0] second_value;
        logic [BYTE_W-1:0]   meta_type;
        logic [LEN_W-1:0]    payload_length;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last_payload;
        logic                end_of_track;
    } t_rec;

endpackage

`default_nettype wire

@@ design/mtep_byte_if.sv @@
// Byte channel carrying raw track chunk bytes.
`default_nettype none

interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;

    modport source (output valid, output track_byte, input ready);
    modport sink   (input valid, input track_byte, output ready);
endinterface

`default_nettype wire

@@ design/mtep_rec_if.sv @@
// Record channel carrying parsed event records.
`default_nettype none

interface mtep_rec_if
    import mtep_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   event_kind;
    logic [DELTA_W-1:0]  delta_time;
    logic [CHAN_W-1:0]   channel_number;
    logic [BYTE_W-1:0]   first_value;
    logic [SECOND_W-1:0] second_value;
    logic [BYTE_W-1:0]   meta_type;
    logic [LEN_W-1:0]    payload_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic                last_payload;
    logic                end_of_track;

    modport source (
        output valid, output event_kind, output delta_time, output channel_number,
        output first_value, output second_value, output meta_type,
        output payload_length, output payload_byte, output last_payload,
        output end_of_track, input ready
    );
    modport sink (
        input valid, input event_kind, input delta_time, input channel_number,
        input first_value, input second_value, input meta_type,
        input payload_length, input payload_byte, input last_payload,
        input end_of_track, output ready
    );
endinterface

`default_nettype wire

@@ design/mtep_front.sv @@
// Byte parser: header skip, delta and length decoding, running status and event classification.
`default_nettype none

module mtep_front
    import mtep_pkg::*;
#(
    parameter int VLQ_BITS = VLQ_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mtep_byte_if.sink   i_byte,
    input  wire         i_q_ready,
    output logic        o_push,
    output t_evt        o_evt
);

    logic accept;
    logic [7:0] b;

    t_phase r_phase, n_phase;
    logic [HDR_CNT_W-1:0] r_cnt, n_cnt;
    logic [VLQ_BITS-1:0] r_acc, n_acc;
    logic [VLQ_BITS-1:0] r_held, n_held;
    logic [VLQ_BITS-1:0] r_rem, n_rem;
    logic [7:0] r_cur, n_cur;
    logic [7:0] r_running, n_running;
    logic [7:0] r_first, n_first;
    logic [7:0] r_mtype, n_mtype;
    logic r_meta, n_meta;

    logic [7:0] s_disp;
    logic is_meta_s, is_sysex_s, is_chan_s, is_short_s;
    logic [VLQ_BITS-1:0] feed_base, vlq_next, rem_dec;
    logic len_zero, last_byte, ends_track;
    logic [DELTA_W+VLQ_BITS-1:0] held_ext, len_ext;

    assign b      = i_byte.track_byte;
    assign accept = i_byte.valid && i_q_ready;
    assign i_byte.ready = i_q_ready;

    // Status in force for the byte after it, or for the running-status byte.
    assign s_disp     = (r_phase == PH_STATUS) ? r_running : r_cur;
    assign is_meta_s  = (s_disp == ST_META);
    assign is_sysex_s = (s_disp == ST_SYSEX) || (s_disp == ST_ESCAPE);
    assign is_chan_s  = s_disp[7] && (s_disp[7:4] != HI_SYSTEM);
    assign is_short_s = (s_disp[7:4] == HI_PROGRAM) || (s_disp[7:4] == HI_CHAN_PRESS);

    // Variable-length step; a value starts from zero when a sysex length begins.
    assign feed_base = ((r_phase == PH_DELTA) || (r_phase == PH_LENGTH)) ? r_acc : '0;
    always_comb begin
        if (|feed_base[VLQ_BITS-1:VLQ_BITS-7]) begin
            vlq_next = '1;
        end else begin
            vlq_next = {feed_base[VLQ_BITS-8:0], b[6:0]};
        end
    end

    assign len_zero   = (vlq_next == '0);
    assign rem_dec    = r_rem - {{(VLQ_BITS-1){1'b0}}, (r_rem != '0)};
    assign last_byte  = (rem_dec == '0);
    assign ends_track = r_meta && (r_mtype == META_EOT);

    assign held_ext = {{DELTA_W{1'b0}}, r_held};
    assign len_ext  = {{LEN_W{1'b0}}, vlq_next};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_cnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_DELTA: begin
                    if (!b[7]) begin
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS, PH_FIRST: begin
                    if (r_phase == PH_STATUS && b[7]) begin
                        n_phase = PH_FIRST;
                    end else if (is_meta_s) begin
                        n_phase = PH_LENGTH;
                    end else if (is_sysex_s) begin
                        if (b[7]) begin
                            n_phase = PH_LENGTH;
                        end else if (len_zero) begin
                            n_phase = PH_DELTA;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else if (is_chan_s && !is_short_s) begin
                        n_phase = PH_SECOND;
                    end else begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_SECOND: n_phase = PH_DELTA;
                PH_LENGTH: begin
                    if (!b[7]) begin
                        if (!len_zero) begin
                            n_phase = PH_PAYLOAD;
                        end else if (ends_track) begin
                            n_phase = PH_HEADER;
                        end else begin
                            n_phase = PH_DELTA;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (last_byte) begin
                        n_phase = ends_track ? PH_HEADER : PH_DELTA;
                    end
                end
                default: n_phase = PH_DELTA;
            endcase
        end
    end

    // Held values and the emitted event.
    always_comb begin
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_held    = r_held;
        n_rem     = r_rem;
        n_cur     = r_cur;
        n_running = r_running;
        n_first   = r_first;
        n_mtype   = r_mtype;
        n_meta    = r_meta;
        o_push    = 1'b0;
        o_evt     = '0;
        o_evt.delta = held_ext[DELTA_W-1:0];
        if (accept) begin
            n_acc = '0;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_cnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                PH_DELTA: begin
                    if (b[7]) begin
                        n_acc = vlq_next;
                    end else begin
                        n_held = vlq_next;
                    end
                end
                PH_STATUS, PH_FIRST: begin
                    if (r_phase == PH_STATUS && b[7]) begin
                        n_cur = b;
                    end else begin
                        n_cur   = s_disp;
                        n_first = b;
                        if (is_meta_s) begin
                            n_meta  = 1'b1;
                            n_mtype = b;
                        end else if (is_sysex_s) begin
                            n_meta = 1'b0;
                            if (b[7]) begin
                                n_acc = vlq_next;
                            end else begin
                                n_rem        = vlq_next;
                                o_push       = 1'b1;
                                o_evt.kind   = KIND_SYSEX_HDR;
                                o_evt.length = len_ext[LEN_W-1:0];
                            end
                        end else if (is_chan_s && is_short_s) begin
                            n_running    = s_disp;
                            o_push       = 1'b1;
                            o_evt.kind   = t_kind'({1'b0, s_disp[6:4]});
                            o_evt.chan   = s_disp[3:0];
                            o_evt.byte_a = b;
                        end
                    end
                end
                PH_SECOND: begin
                    n_running    = r_cur;
                    o_push       = 1'b1;
                    o_evt.kind   = t_kind'({1'b0, r_cur[6:4]});
                    o_evt.chan   = r_cur[3:0];
                    o_evt.byte_a = r_first;
                    o_evt.byte_b = b;
                end
                PH_LENGTH: begin
                    if (b[7]) begin
                        n_acc = vlq_next;
                    end else begin
                        n_rem        = vlq_next;
                        o_push       = 1'b1;
                        o_evt.kind   = r_meta ? KIND_META_HDR : KIND_SYSEX_HDR;
                        o_evt.length = len_ext[LEN_W-1:0];
                        o_evt.byte_a = r_meta ? r_mtype : 8'h00;
                        o_evt.flag   = ends_track;
                    end
                end
                PH_PAYLOAD: begin
                    n_rem        = rem_dec;
                    o_push       = 1'b1;
                    o_evt.kind   = KIND_PAYLOAD;
                    o_evt.delta  = '0;
                    o_evt.byte_a = b;
                    o_evt.flag   = last_byte;
                end
                default: begin
                    n_acc = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_held    <= '0;
            r_rem     <= '0;
            r_cur     <= '0;
            r_running <= '0;
            r_first   <= '0;
            r_mtype   <= '0;
            r_meta    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_acc     <= n_acc;
            r_held    <= n_held;
            r_rem     <= n_rem;
            r_cur     <= n_cur;
            r_running <= n_running;
            r_first   <= n_first;
            r_mtype   <= n_mtype;
            r_meta    <= n_meta;
        end
    end

endmodule

`default_nettype wire

@@ design/mtep_queue.sv @@
// Two-entry event queue between the parser and the output stage.
`default_nettype none

module mtep_queue
    import mtep_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_evt  i_evt,
    output logic  o_ready,
    output logic  o_valid,
    output t_evt  o_evt,
    input  wire   i_pop
);

    t_evt r_mem [0:1];
    logic r_wr, r_rd;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

@@ design/mtep_back.sv @@
// Output stage: expands queued events into full records and holds them for the receiver.
`default_nettype none

module mtep_back
    import mtep_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  t_evt         i_evt,
    output logic         o_pop,
    mtep_rec_if.source   o_rec
);

    logic r_valid;
    t_rec r_rec, n_rec;

    assign o_pop = i_valid && (!r_valid || o_rec.ready);

    // Only the fields that belong to the kind are carried; the rest read as zero.
    always_comb begin
        n_rec = '0;
        n_rec.event_kind = i_evt.kind;
        case (i_evt.kind)
            KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESS, KIND_CONTROL,
            KIND_PROGRAM, KIND_CHAN_PRESS: begin
                n_rec.delta_time     = i_evt.delta;
                n_rec.channel_number = i_evt.chan;
                n_rec.first_value    = i_evt.byte_a;
                n_rec.second_value   = {7'b0, i_evt.byte_b};
            end
            KIND_PITCH_WHEEL: begin
                n_rec.delta_time     = i_evt.delta;
                n_rec.channel_number = i_evt.chan;
                n_rec.first_value    = i_evt.byte_a;
                n_rec.second_value   = {i_evt.byte_b, 7'b0} | {7'b0, i_evt.byte_a};
            end
            KIND_META_HDR: begin
                n_rec.delta_time     = i_evt.delta;
                n_rec.meta_type      = i_evt.byte_a;
                n_rec.payload_length = i_evt.length;
                n_rec.end_of_track   = i_evt.flag;
            end
            KIND_SYSEX_HDR: begin
                n_rec.delta_time     = i_evt.delta;
                n_rec.payload_length = i_evt.length;
            end
            KIND_PAYLOAD: begin
                n_rec.payload_byte = i_evt.byte_a;
                n_rec.last_payload = i_evt.flag;
            end
            default: begin
                n_rec = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_rec.valid          = r_valid;
    assign o_rec.event_kind     = r_rec.event_kind;
    assign o_rec.delta_time     = r_rec.delta_time;
    assign o_rec.channel_number = r_rec.channel_number;
    assign o_rec.first_value    = r_rec.first_value;
    assign o_rec.second_value   = r_rec.second_value;
    assign o_rec.meta_type      = r_rec.meta_type;
    assign o_rec.payload_length = r_rec.payload_length;
    assign o_rec.payload_byte   = r_rec.payload_byte;
    assign o_rec.last_payload   = r_rec.last_payload;
    assign o_rec.end_of_track   = r_rec.end_of_track;

endmodule

`default_nettype wire

@@ design/midi_track_event_parser.sv @@
// Top level of the MIDI track event parser.
//
// The block takes the bytes of a MIDI track chunk on i_byte, one byte per
// transfer, and delivers parsed event records on o_rec. Both channels are
// valid/ready handshakes; a transfer happens on a rising edge of i_clk where
// valid and ready are both high.
// The first eight bytes of a chunk (id and size) are skipped. Each event's
// delta time is decoded, running status is honored, and one record comes out
// per channel event. Meta and sysex events give a header record followed by
// one record per payload byte, the last one marked. The end-of-track meta
// event re-arms the header skip for a following chunk.
// Throughput is one byte per cycle while the two-entry queue has room.
// A byte that completes a record has that record written into the two-entry
// queue at the byte's transfer; the output stage then moves it into the
// output register, from which the receiver takes it on o_rec.
// When the receiver stalls, the output register holds its record and the
// queue absorbs two more; i_byte.ready falls only once the queue is full.
// A synchronous active-low reset returns the parser to the header skip and
// empties the queue and output register.
`default_nettype none

module midi_track_event_parser
    import mtep_pkg::*;
#(
    parameter int VLQ_BITS = VLQ_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mtep_byte_if.sink    i_byte,
    mtep_rec_if.source   o_rec
);

    logic push, q_ready, q_valid, pop;
    t_evt front_evt, q_evt;

    // Parser: classifies each byte and emits a compact event when one completes.
    mtep_front #(
        .VLQ_BITS (VLQ_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_evt     (front_evt)
    );

    // Queue that lets the parser keep running while the receiver stalls briefly.
    mtep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (front_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_evt   (q_evt),
        .i_pop   (pop)
    );

    // Output stage: expands each event into a full record and registers it.
    mtep_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_evt   (q_evt),
        .o_pop   (pop),
        .o_rec   (o_rec)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench of the MIDI track event parser: directed bytes, then random tracks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtep_pkg::*;

    // Run lengths and limits.
    localparam int RANDOM_ITEMS   = 2000;
    localparam int PAUSE_EVERY    = 700;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int RESET_CYCLES   = 10;

    // Largest value a variable-length quantity can hold before it saturates.
    localparam logic [63:0] VLQ_MAX = (64'd1 << VLQ_BITS_DEF) - 64'd1;

    // Byte codes used to build tracks.
    localparam logic [7:0] VLQ_MORE       = 8'h80;  // continuation flag of a length byte
    localparam logic [7:0] ST_CHANNEL_MIN = 8'h80;
    localparam logic [7:0] ST_CHANNEL_MAX = 8'hEF;
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [7:0] ST_SYSTEM_LAST = 8'hFE;
    localparam logic [3:0] HI_PITCH       = 4'hE;

    typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SLOW, RX_PATTERN} t_rx_mode;

    // One row of the directed stimulus: the byte, and optionally the record it must give.
    typedef struct {
        logic [7:0] data;
        bit         has_rec;
        t_rec       rec;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mtep_byte_if byte_ch ();
    mtep_rec_if  rec_ch ();

    midi_track_event_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_rec   (rec_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser state as the testbench tracks it. The initial values are the
    // state right after reset.
    // ------------------------------------------------------------------
    t_phase             trk_phase  = PH_HEADER;
    int unsigned        hdr_seen   = 0;
    logic [63:0]        vlq_acc    = '0;
    bit                 vlq_sat    = 1'b0;
    logic [DELTA_W-1:0] delta_hold = '0;
    logic [7:0]         cur_status = '0;
    logic [7:0]         run_status = '0;
    logic [7:0]         first_hold = '0;
    logic [7:0]         mtype_hold = '0;
    logic [LEN_W-1:0]   pay_left   = '0;
    bit                 in_meta    = 1'b0;

    // Records still owed by the block, oldest first.
    t_rec expected_records[$];

    t_stim_row   directed_rows[$];
    logic [7:0]  track_bytes[$];
    int unsigned burst_left     = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    function automatic t_rec make_rec(input t_kind kind, input logic [DELTA_W-1:0] delta,
                                      input logic [CHAN_W-1:0] chan, input logic [7:0] v1,
                                      input logic [SECOND_W-1:0] v2, input logic [7:0] mtype,
                                      input logic [LEN_W-1:0] len, input logic [7:0] pbyte,
                                      input bit last, input bit eot);
        t_rec r;
        r.event_kind     = kind;
        r.delta_time     = delta;
        r.channel_number = chan;
        r.first_value    = v1;
        r.second_value   = v2;
        r.meta_type      = mtype;
        r.payload_length = len;
        r.payload_byte   = pbyte;
        r.last_payload   = last;
        r.end_of_track   = eot;
        return r;
    endfunction

    function automatic void vlq_restart();
        vlq_acc = '0;
        vlq_sat = 1'b0;
    endfunction

    // Shifts in one length byte. Once the value can no longer take seven
    // more bits it pins at the maximum until its final byte.
    function automatic bit vlq_take(input logic [7:0] b);
        if (vlq_sat || vlq_acc > (VLQ_MAX >> 7)) begin
            vlq_sat = 1'b1;
            vlq_acc = VLQ_MAX;
        end else begin
            vlq_acc = (vlq_acc << 7) | {57'd0, b[6:0]};
        end
        return !b[7];
    endfunction

    // Closes an event. The end-of-track meta sends the parser back to the
    // chunk header skip.
    function automatic void end_event();
        if (in_meta && mtype_hold == META_EOT) begin
            trk_phase = PH_HEADER;
            hdr_seen  = 0;
        end else begin
            trk_phase = PH_DELTA;
        end
        vlq_restart();
    endfunction

    function automatic bit length_done(output t_rec r);
        t_kind kind;
        kind     = in_meta ? KIND_META_HDR : KIND_SYSEX_HDR;
        pay_left = vlq_acc[LEN_W-1:0];
        r = make_rec(kind, delta_hold, '0, '0, '0, in_meta ? mtype_hold : 8'd0,
                     vlq_acc[LEN_W-1:0], '0, 1'b0, in_meta && mtype_hold == META_EOT);
        if (pay_left == 0) begin
            end_event();
        end else begin
            trk_phase = PH_PAYLOAD;
        end
        return 1'b1;
    endfunction

    function automatic bit channel_done(input logic [7:0] second, output t_rec r);
        t_kind               kind;
        logic [SECOND_W-1:0] v2;
        kind = t_kind'({1'b0, cur_status[6:4]});
        // The pitch wheel packs both data bytes into one value, first byte low.
        if (kind == KIND_PITCH_WHEEL) begin
            v2 = {second, 7'd0} | {7'd0, first_hold};
        end else begin
            v2 = {7'd0, second};
        end
        run_status = cur_status;
        trk_phase  = PH_DELTA;
        vlq_restart();
        r = make_rec(kind, delta_hold, cur_status[3:0], first_hold, v2, '0, '0, '0, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    // Handles the first byte after a status, or the data byte that reuses
    // the running status.
    function automatic bit dispatch(input logic [7:0] f, output t_rec r);
        first_hold = f;
        if (cur_status == ST_META) begin
            in_meta    = 1'b1;
            mtype_hold = f;
            vlq_restart();
            trk_phase  = PH_LENGTH;
            return 1'b0;
        end
        // A sysex length starts right at this byte.
        if (cur_status == ST_SYSEX || cur_status == ST_ESCAPE) begin
            in_meta = 1'b0;
            vlq_restart();
            if (vlq_take(f)) begin
                return length_done(r);
            end
            trk_phase = PH_LENGTH;
            return 1'b0;
        end
        if (cur_status[7] && cur_status[7:4] != HI_SYSTEM) begin
            if (cur_status[7:4] == HI_PROGRAM || cur_status[7:4] == HI_CHAN_PRESS) begin
                return channel_done(8'd0, r);
            end
            trk_phase = PH_SECOND;
            return 1'b0;
        end
        // Other system status, or running status that was never set: the
        // byte is swallowed.
        trk_phase = PH_DELTA;
        vlq_restart();
        return 1'b0;
    endfunction

    // Advances the tracked parser by one track byte; returns 1 when the byte
    // completes a record, which is then left in r.
    function automatic bit parse_byte(input logic [7:0] b, output t_rec r);
        bit last;
        r = '0;
        case (trk_phase)
            PH_HEADER: begin
                if (hdr_seen + 1 >= HEADER_BYTES) begin
                    hdr_seen  = 0;
                    trk_phase = PH_DELTA;
                    vlq_restart();
                end else begin
                    hdr_seen++;
                end
                return 1'b0;
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    cur_status = run_status;
                    return dispatch(b, r);
                end
                cur_status = b;
                trk_phase  = PH_FIRST;
                return 1'b0;
            end
            PH_FIRST:  return dispatch(b, r);
            PH_SECOND: return channel_done(b, r);
            PH_LENGTH: begin
                if (vlq_take(b)) begin
                    return length_done(r);
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                if (pay_left != 0) begin
                    pay_left--;
                end
                last = (pay_left == 0);
                r = make_rec(KIND_PAYLOAD, '0, '0, '0, '0, '0, '0, b, last, 1'b0);
                if (last) begin
                    end_event();
                end
                return 1'b1;
            end
            default: begin
                if (trk_phase != PH_DELTA) begin
                    trk_phase = PH_DELTA;
                    vlq_restart();
                end
                if (vlq_take(b)) begin
                    delta_hold = vlq_acc[DELTA_W-1:0];
                    trk_phase  = PH_STATUS;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Track builders for the random part. Each appends bytes to
    // track_bytes, which the stimulus then sends one transfer at a time.
    // ------------------------------------------------------------------
    function automatic void put_vlq(input logic [27:0] v, input int unsigned pad);
        logic [7:0] groups[$];
        groups.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0) begin
            groups.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        // Leading empty groups keep the value and stretch the encoding.
        repeat (pad) track_bytes.push_back(VLQ_MORE);
        foreach (groups[i]) track_bytes.push_back(groups[i]);
    endfunction

    function automatic void put_delta();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) begin
            put_vlq(28'd0, 0);
        end else if (pick < 16) begin
            put_vlq(28'($urandom_range(1, 300)), ($urandom_range(0, 3) == 0));
        end else if (pick < 18) begin
            put_vlq(28'($urandom()), 0);
        end else begin
            // Long runs of continuation bytes push the value past its width.
            repeat ($urandom_range(4, 6)) track_bytes.push_back(VLQ_MORE | 8'($urandom()));
            track_bytes.push_back(8'($urandom_range(0, 127)));
        end
    endfunction

    // Declared length and the payload bytes of a meta or sysex event.
    function automatic void put_payload();
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        put_vlq(28'(len), ($urandom_range(0, 4) == 0));
        repeat (len) track_bytes.push_back(8'($urandom()));
    endfunction

    // Mostly clean data; now and then bit 7 is set, which a channel event
    // still takes as data.
    function automatic logic [7:0] rand_data_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 127));
    endfunction

    function automatic void put_event();
        int unsigned pick;
        logic [7:0]  status;
        pick = $urandom_range(0, 99);
        put_delta();
        if (pick < 55) begin
            status = 8'($urandom_range(ST_CHANNEL_MIN, ST_CHANNEL_MAX));
            if (run_status != 0 && $urandom_range(0, 2) == 0) begin
                // Running status: no status byte, the first data byte must stay below 0x80.
                status = run_status;
                track_bytes.push_back(8'($urandom_range(0, 127)));
            end else begin
                track_bytes.push_back(status);
                track_bytes.push_back(rand_data_byte());
            end
            if (status[7:4] != HI_PROGRAM && status[7:4] != HI_CHAN_PRESS) begin
                track_bytes.push_back(rand_data_byte());
            end
        end else if (pick < 72) begin
            track_bytes.push_back(ST_META);
            track_bytes.push_back(8'($urandom()));
            put_payload();
        end else if (pick < 86) begin
            track_bytes.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
            put_payload();
        end else begin
            status = 8'($urandom_range(ST_TIME_CODE, ST_SYSTEM_LAST));
            if (status == ST_ESCAPE) begin
                status = ST_TIME_CODE;
            end
            track_bytes.push_back(status);
            track_bytes.push_back(8'($urandom()));
        end
    endfunction

    function automatic void add_row(input logic [7:0] data, input bit has_rec = 1'b0,
                                    input t_rec rec = '0);
        t_stim_row row;
        row.data    = data;
        row.has_rec = has_rec;
        row.rec     = rec;
        directed_rows.push_back(row);
    endfunction

    // Sends one track byte. The sender works in bursts; a new burst may
    // start after a random gap. On acceptance the byte goes through the
    // tracked parser, and the record it owes (typed in or predicted) is queued.
    task automatic transfer_byte(input logic [7:0] b, input bit has_rec, input t_rec typed_rec);
        int unsigned gap;
        bit          produced;
        t_rec        predicted;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 32);
            if (gap != 0) begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        byte_ch.valid      <= 1'b1;
        byte_ch.track_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        produced = parse_byte(b, predicted);
        if (has_rec) begin
            expected_records.push_back(typed_rec);
        end else if (produced) begin
            expected_records.push_back(predicted);
        end
    endtask

    // The sender holds off until every owed record has come out, then lets
    // the pipeline settle.
    task automatic pause_until_drained();
        byte_ch.valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode, redrawn at random whenever its countdown ends,
    // from always ready down to long stalls and a rotating pattern.
    // ------------------------------------------------------------------
    t_rx_mode    rx_mode    = RX_ALWAYS;
    logic [7:0]  stall_mask = 8'h01;
    int unsigned rx_count   = 0;

    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode    <= t_rx_mode'($urandom_range(0, 3));
            stall_mask <= 8'($urandom()) | 8'h01;
            rx_count   <= $urandom_range(20, 200);
        end else begin
            rx_count <= rx_count - 1;
            case (rx_mode)
                RX_ALWAYS: rec_ch.ready <= 1'b1;
                RX_COIN:   rec_ch.ready <= 1'($urandom_range(0, 1));
                RX_SLOW:   rec_ch.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    rec_ch.ready <= stall_mask[0];
                    stall_mask   <= {stall_mask[0], stall_mask[7:1]};
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Record checking. Outputs are sampled at the rising edge, before the
    // block updates them, so a transfer is seen exactly once.
    // ------------------------------------------------------------------
    function automatic string rec_text(input t_rec r);
        return $sformatf({"kind=%0d delta=%0h chan=%0d v1=%0h v2=%0h mtype=%0h len=%0h",
                          " pbyte=%0h last=%0b eot=%0b"},
                         r.event_kind, r.delta_time, r.channel_number, r.first_value,
                         r.second_value, r.meta_type, r.payload_length, r.payload_byte,
                         r.last_payload, r.end_of_track);
    endfunction

    function automatic string first_bad_field(input t_rec e, input t_rec g);
        if (g.event_kind     !== e.event_kind)     return "event_kind";
        if (g.delta_time     !== e.delta_time)     return "delta_time";
        if (g.channel_number !== e.channel_number) return "channel_number";
        if (g.first_value    !== e.first_value)    return "first_value";
        if (g.second_value   !== e.second_value)   return "second_value";
        if (g.meta_type      !== e.meta_type)      return "meta_type";
        if (g.payload_length !== e.payload_length) return "payload_length";
        if (g.payload_byte   !== e.payload_byte)   return "payload_byte";
        if (g.last_payload   !== e.last_payload)   return "last_payload";
        if (g.end_of_track   !== e.end_of_track)   return "end_of_track";
        return "";
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin : rec_check
        t_rec  got;
        t_rec  want;
        string bad;
        if (i_rst_n && rec_ch.valid && rec_ch.ready) begin
            got.event_kind     = t_kind'(rec_ch.event_kind);
            got.delta_time     = rec_ch.delta_time;
            got.channel_number = rec_ch.channel_number;
            got.first_value    = rec_ch.first_value;
            got.second_value   = rec_ch.second_value;
            got.meta_type      = rec_ch.meta_type;
            got.payload_length = rec_ch.payload_length;
            got.payload_byte   = rec_ch.payload_byte;
            got.last_payload   = rec_ch.last_payload;
            got.end_of_track   = rec_ch.end_of_track;
            if (expected_records.size() == 0) begin
                log_mismatch({"record with none owed: ", rec_text(got)});
            end else begin
                want = expected_records.pop_front();
                bad  = first_bad_field(want, got);
                if (bad != "") begin
                    log_mismatch({"wrong ", bad, "\n  expected ", rec_text(want),
                                  "\n  actual   ", rec_text(got)});
                end
            end
        end
    end

    // The watchdog counts cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_items;
        int unsigned next_pause;
        int unsigned cut;
        byte_ch.valid      = 1'b0;
        byte_ch.track_byte = '0;
        rec_ch.ready       = 1'b0;

        // Chunk header: id and size are skipped; its bytes swing every data line.
        add_row(8'hFF);
        add_row(8'h00);
        add_row(8'hAA);
        add_row(8'h55);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'h00);
        add_row(8'hFF);
        // A data byte before any channel status has nothing to run on and is dropped.
        add_row(8'h00);
        add_row(8'h40);
        // A delta time that overflows its width saturates.
        add_row(8'hFF);
        add_row(8'hFF);
        add_row(8'hFF);
        add_row(8'hFF);
        add_row(8'h00);
        // Pitch wheel on the last channel at full scale; the second data byte has bit 7 set.
        add_row({HI_PITCH, 4'hF});
        add_row(8'h7F);
        add_row(8'hFF, 1'b1, make_rec(KIND_PITCH_WHEEL, VLQ_MAX[DELTA_W-1:0], 4'hF, 8'h7F,
                                      15'h7FFF, '0, '0, '0, 1'b0, 1'b0));
        // A system status other than sysex or meta eats one byte and gives nothing.
        add_row(8'h00);
        add_row(ST_TIME_CODE);
        add_row(8'h33);
        // Sysex of zero length: the header is the whole event.
        add_row(8'h00);
        add_row(ST_SYSEX);
        add_row(8'h00, 1'b1, make_rec(KIND_SYSEX_HDR, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        // End of track re-arms the header skip.
        add_row(8'h00);
        add_row(ST_META);
        add_row(META_EOT);
        add_row(8'h00, 1'b1, make_rec(KIND_META_HDR, '0, '0, '0, '0, META_EOT, '0, '0,
                                      1'b0, 1'b1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            transfer_byte(directed_rows[i].data, directed_rows[i].has_rec, directed_rows[i].rec);
        end
        pause_until_drained();

        // Random tracks: a header, a run of well-formed events with random
        // content, some of them cut short or followed by stray bytes, and an
        // end-of-track meta.
        random_items = 0;
        next_pause   = PAUSE_EVERY;
        while (random_items < RANDOM_ITEMS) begin
            repeat (HEADER_BYTES) transfer_byte(8'($urandom()), 1'b0, '0);
            repeat ($urandom_range(2, 40)) begin
                track_bytes.delete();
                put_event();
                if ($urandom_range(0, 99) < 5 && track_bytes.size() > 1) begin
                    cut = $urandom_range(1, track_bytes.size() - 1);
                    repeat (cut) void'(track_bytes.pop_back());
                end
                if ($urandom_range(0, 99) < 4) begin
                    repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom()));
                end
                foreach (track_bytes[i]) transfer_byte(track_bytes[i], 1'b0, '0);
                random_items += track_bytes.size();
                if (random_items >= next_pause) begin
                    pause_until_drained();
                    next_pause += PAUSE_EVERY;
                end
            end
            track_bytes.delete();
            put_delta();
            track_bytes.push_back(ST_META);
            track_bytes.push_back(META_EOT);
            put_payload();
            foreach (track_bytes[i]) transfer_byte(track_bytes[i], 1'b0, '0);
            random_items += track_bytes.size();
        end

        pause_until_drained();
        if (mismatch_count == 0 && expected_records.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ midi_track_event_parser.f @@
design/mtep_pkg.sv
design/mtep_byte_if.sv
design/mtep_rec_if.sv
design/mtep_front.sv
design/mtep_queue.sv
design/mtep_back.sv
design/midi_track_event_parser.sv
bench/testbench.sv
